[rtl/weis_pkg.sv]
// Package for the width-encoded integer set.
// Holds sizes, command codes and width codes; no dependencies.
package weis_pkg;

  localparam int WEIS_DEPTH = 64;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  localparam logic [2:0] FUNC_INSERT    = 3'd0;
  localparam logic [2:0] FUNC_DELETE    = 3'd1;
  localparam logic [2:0] FUNC_FIND      = 3'd2;
  localparam logic [2:0] FUNC_SORT_ASC  = 3'd3;
  localparam logic [2:0] FUNC_SORT_DESC = 3'd4;

  localparam logic [1:0] KIND_16 = 2'd0;
  localparam logic [1:0] KIND_32 = 2'd1;
  localparam logic [1:0] KIND_64 = 2'd2;

  function automatic logic [63:0] cut_to_kind(input logic [63:0] v, input logic [1:0] kind);
    logic [63:0] r;
    r = v;
    if (kind == KIND_16) r = {{48{v[15]}}, v[15:0]};
    else if (kind == KIND_32) r = {{32{v[31]}}, v[31:0]};
    return r;
  endfunction

  function automatic logic signed_less(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

[rtl/width_encoded_integer_set_top.sv]
// Top level of the width-encoded integer set: command decode, sequencer and table memory.
// Depends on weis_pkg.
//
// channel  dir  fields
// s_*      in   tdata: func[2:0], value[66:3]; tuser: value_kind[1:0]
// m_*      out  tdata: ok[0], element_count[7:1], width_tag[9:8], byte_count[19:10]
//
// One command at a time through a single table memory (one write, one registered read port).
// Delete scans for the value, then shifts the later entries down.
// Sort and find: insertion sort; find then does a binary search of the ascending table.
// Reset clears count and tag; table contents are undefined until written.
// A result held on m_* while m_tready is low stalls the sequencer before its next command.
module width_encoded_integer_set_top #(
  parameter int DEPTH = weis_pkg::WEIS_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [weis_pkg::IN_DATA_W-1:0]  s_tdata,   // func, value
  input  logic [1:0]                      s_tuser,   // value_kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [weis_pkg::OUT_DATA_W-1:0] m_tdata    // ok, element_count, width_tag, byte_count
);
  import weis_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_EXEC     = 12'b000000000010,
    S_SORT_KEY = 12'b000000000100,
    S_SORT_LD  = 12'b000000001000,
    S_SORT_RD  = 12'b000000010000,
    S_SORT_CMP = 12'b000000100000,
    S_BS       = 12'b000001000000,
    S_BS_CMP   = 12'b000010000000,
    S_DEL_RD   = 12'b000100000000,
    S_DEL_CMP  = 12'b001000000000,
    S_SH_RD    = 12'b010000000000,
    S_OUT      = 12'b100000000000
  } state_t;

  state_t state, state_next;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;
  logic wr_en;

  logic [2:0]  func;
  logic [63:0] val;
  logic [1:0]  kind;
  logic [63:0] key, key_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]  tag, tag_next;
  logic [CW-1:0] i, i_next, j, j_next, lo, lo_next, hi, hi_next, mid, mid_next;
  logic ok, ok_next, desc, desc_next, finding, finding_next, shifting, shifting_next;
  logic [1:0] in_kind;
  logic move;
  logic [CW-1:0] mid_calc;
  logic [CW+10:0] bytes_wide;
  logic [CW+6:0] count_wide;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign s_tready = (state == S_IDLE);
  assign in_kind  = (s_tuser == 2'd3) ? KIND_64 : s_tuser;
  assign move     = desc ? signed_less(rd_data, key) : signed_less(key, rd_data);
  assign mid_calc = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func <= s_tdata[2:0];
      kind <= in_kind;
      val  <= cut_to_kind(s_tdata[66:3], in_kind);
    end
    key <= key_next;
    i   <= i_next;
    j   <= j_next;
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    ok  <= ok_next;
    desc <= desc_next;
    finding <= finding_next;
    shifting <= shifting_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    tag_next = tag;
    key_next = key;
    i_next = i;
    j_next = j;
    lo_next = lo;
    hi_next = hi;
    mid_next = mid;
    ok_next = ok;
    desc_next = desc;
    finding_next = finding;
    shifting_next = shifting;
    rd_addr = i[AW-1:0];
    wr_addr = j[AW-1:0];
    wr_data = key;
    wr_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        ok_next = 1'b0;
        i_next = CW'(1);
        desc_next = 1'b0;
        finding_next = 1'b0;
        state_next = S_OUT;
        unique case (func)
          FUNC_INSERT: begin
            if (count < CW'(DEPTH)) begin
              wr_en = 1'b1;
              wr_addr = count[AW-1:0];
              wr_data = val;
              count_next = count + CW'(1);
              if (kind > tag) tag_next = kind;
              ok_next = 1'b1;
            end
          end
          FUNC_DELETE: begin
            if (kind == tag) begin
              ok_next = 1'b1;
              i_next = '0;
              state_next = S_DEL_RD;
            end
          end
          FUNC_FIND: begin
            if (kind <= tag) begin
              finding_next = 1'b1;
              state_next = S_SORT_KEY;
            end
          end
          FUNC_SORT_ASC: begin
            ok_next = 1'b1;
            state_next = S_SORT_KEY;
          end
          FUNC_SORT_DESC: begin
            ok_next = 1'b1;
            desc_next = 1'b1;
            state_next = S_SORT_KEY;
          end
          default: ;
        endcase
      end
      S_SORT_KEY: begin
        rd_addr = i[AW-1:0];
        if (i < count) begin
          state_next = S_SORT_LD;
        end else if (finding) begin
          lo_next = '0;
          hi_next = count;
          state_next = S_BS;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SORT_LD: begin
        key_next = rd_data;
        j_next = i;
        state_next = S_SORT_RD;
      end
      S_SORT_RD: begin
        rd_addr = AW'(j - CW'(1));
        if (j == '0) begin
          wr_en = 1'b1;
          i_next = i + CW'(1);
          state_next = S_SORT_KEY;
        end else begin
          state_next = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        wr_en = 1'b1;
        if (move) begin
          wr_data = rd_data;
          j_next = j - CW'(1);
          state_next = S_SORT_RD;
        end else begin
          i_next = i + CW'(1);
          state_next = S_SORT_KEY;
        end
      end
      S_BS: begin
        rd_addr = mid_calc[AW-1:0];
        mid_next = mid_calc;
        if (lo < hi) state_next = S_BS_CMP;
        else begin
          ok_next = 1'b0;
          state_next = S_OUT;
        end
      end
      S_BS_CMP: begin
        if (rd_data == val) begin
          ok_next = 1'b1;
          state_next = S_OUT;
        end else begin
          if (signed_less(rd_data, val)) lo_next = mid + CW'(1);
          else hi_next = mid;
          state_next = S_BS;
        end
      end
      S_DEL_RD: begin
        rd_addr = i[AW-1:0];
        if (i < count) state_next = S_DEL_CMP;
        else state_next = S_OUT;
      end
      S_DEL_CMP: begin
        if (rd_data == val) begin
          j_next = i;
          shifting_next = 1'b0;
          state_next = S_SH_RD;
        end else begin
          i_next = i + CW'(1);
          state_next = S_DEL_RD;
        end
      end
      S_SH_RD: begin
        rd_addr = AW'(j + CW'(1));
        wr_data = rd_data;
        if (shifting) begin
          wr_en = 1'b1;
          j_next = j + CW'(1);
          shifting_next = 1'b0;
        end else if ((j + CW'(1)) < count) begin
          shifting_next = 1'b1;
        end else begin
          count_next = count - CW'(1);
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign bytes_wide = (CW + 11)'(count) << (tag + 2'd1);
  assign count_wide = (CW + 7)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      tag <= KIND_16;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      tag <= tag_next;
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, bytes_wide[9:0], tag, count_wide[6:0], ok};
    end
  end

endmodule

[rtl/weis_checker.sv]
// Port-level checker for the width-encoded integer set, with its bind.
// Depends on weis_pkg and width_encoded_integer_set_top.
module weis_checker #(
  parameter int DEPTH = weis_pkg::WEIS_DEPTH
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [weis_pkg::OUT_DATA_W-1:0] m_tdata
);
  import weis_pkg::*;

  logic [9:0] exp_bytes;
  assign exp_bytes = 10'(m_tdata[7:1]) << (m_tdata[9:8] + 2'd1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_tag_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:8] != 2'd3)
    else $error("bad width tag");

  a_bytes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (DEPTH < 128) |-> m_tdata[19:10] == exp_bytes)
    else $error("byte count mismatch");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken while busy");

endmodule

bind width_encoded_integer_set_top weis_checker #(.DEPTH(DEPTH)) u_weis_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
